>>> rtl/core/cst_pkg.sv
// Shared types, constants and the grain step table of the cardinal spline tessellator.
package cst_pkg;

  localparam int DEF_COORD_WIDTH = 24;
  localparam int MAX_GRAIN       = 31;

  localparam int TENSION_W  = 15;
  localparam int GRAIN_W    = 5;
  localparam int U_W        = 16;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 15;

  localparam logic [CFG_IDX_W-1:0] REG_TENSION = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GRAIN   = 2'd1;

  localparam logic [TENSION_W-1:0] TENSION_RESET = 15'd8192;
  localparam logic [GRAIN_W-1:0]   GRAIN_RESET   = 5'd8;

  // one micro-op for the shared multiply-add unit
  typedef struct packed {
    logic           load;   // capture window differences
    logic           issue;  // multiply this cycle
    logic           setup;  // coefficient op (else Horner op)
    logic           axis;   // 0 = x, 1 = y
    logic [1:0]     k;      // coefficient index
    logic [U_W-1:0] u;
  } cst_op_t;

  // sequencer to top-level control
  typedef struct packed {
    logic in_ready;
    logic hist_upd;
    logic out_load;
    logic out_final;
    logic out_end;
    logic span_b;
  } cst_ctl_t;

  typedef struct packed {
    logic [U_W-1:0]     q;
    logic [GRAIN_W-1:0] r;
  } cst_step_t;

  // 65536 = q*g + r; q kept mod 2^16 (g = 1 never steps u)
  function automatic cst_step_t u_step(input logic [GRAIN_W-1:0] g);
    cst_step_t s;
    case (g)
      5'd1:    s = '{q: 16'd0,     r: 5'd0};
      5'd2:    s = '{q: 16'd32768, r: 5'd0};
      5'd3:    s = '{q: 16'd21845, r: 5'd1};
      5'd4:    s = '{q: 16'd16384, r: 5'd0};
      5'd5:    s = '{q: 16'd13107, r: 5'd1};
      5'd6:    s = '{q: 16'd10922, r: 5'd4};
      5'd7:    s = '{q: 16'd9362,  r: 5'd2};
      5'd8:    s = '{q: 16'd8192,  r: 5'd0};
      5'd9:    s = '{q: 16'd7281,  r: 5'd7};
      5'd10:   s = '{q: 16'd6553,  r: 5'd6};
      5'd11:   s = '{q: 16'd5957,  r: 5'd9};
      5'd12:   s = '{q: 16'd5461,  r: 5'd4};
      5'd13:   s = '{q: 16'd5041,  r: 5'd3};
      5'd14:   s = '{q: 16'd4681,  r: 5'd2};
      5'd15:   s = '{q: 16'd4369,  r: 5'd1};
      5'd16:   s = '{q: 16'd4096,  r: 5'd0};
      5'd17:   s = '{q: 16'd3855,  r: 5'd1};
      5'd18:   s = '{q: 16'd3640,  r: 5'd16};
      5'd19:   s = '{q: 16'd3449,  r: 5'd5};
      5'd20:   s = '{q: 16'd3276,  r: 5'd16};
      5'd21:   s = '{q: 16'd3120,  r: 5'd16};
      5'd22:   s = '{q: 16'd2978,  r: 5'd20};
      5'd23:   s = '{q: 16'd2849,  r: 5'd9};
      5'd24:   s = '{q: 16'd2730,  r: 5'd16};
      5'd25:   s = '{q: 16'd2621,  r: 5'd11};
      5'd26:   s = '{q: 16'd2520,  r: 5'd16};
      5'd27:   s = '{q: 16'd2427,  r: 5'd7};
      5'd28:   s = '{q: 16'd2340,  r: 5'd16};
      5'd29:   s = '{q: 16'd2259,  r: 5'd25};
      5'd30:   s = '{q: 16'd2184,  r: 5'd16};
      5'd31:   s = '{q: 16'd2114,  r: 5'd2};
      default: s = '{q: 16'd0,     r: 5'd0};
    endcase
    return s;
  endfunction

endpackage

>>> rtl/core/cardinal_spline_tessellator.sv
// Top level of the cardinal spline tessellator: config, point history, output register.
//
//   channel | direction | handshake               | payload
//   --------+-----------+-------------------------+-------------------------------
//   cfg     | in        | cfg_we_i                | cfg_idx_i, cfg_data_i
//   in      | in        | in_valid_i / in_ready_o | point_x_i, point_y_i, is_last_i
//   out     | out       | out_valid_o/out_ready_i | curve_x_o, curve_y_o, run_end_o
//
// Each input beat is worked through the single multiplier: six coefficient multiplies per
// span, six Horner multiplies per point. The final point of a curve is also sent out as
// a beat of its own. Reset gives tension 0.5, grain 8 and an empty history. A stalled
// output beat holds in the output register and the sequencer waits; a new input beat is
// taken while the last result still waits.
module cardinal_spline_tessellator #(
  parameter int COORD_WIDTH = cst_pkg::DEF_COORD_WIDTH
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [cst_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [cst_pkg::CFG_DATA_W-1:0]    cfg_data_i,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic signed [COORD_WIDTH-1:0]     point_x_i,
  input  logic signed [COORD_WIDTH-1:0]     point_y_i,
  input  logic                              is_last_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic signed [COORD_WIDTH-1:0]     curve_x_o,
  output logic signed [COORD_WIDTH-1:0]     curve_y_o,
  output logic                              run_end_o
);
  import cst_pkg::*;

  logic [TENSION_W-1:0] tension_q;
  logic [GRAIN_W-1:0]   grain_q;

  logic [COORD_WIDTH-1:0]      cur_x_q, cur_y_q;
  logic                        last_q;
  logic [2:0][COORD_WIDTH-1:0] hist_x_q, hist_y_q;
  logic [1:0]                  seen_q;

  logic                   out_valid_q;
  logic [COORD_WIDTH-1:0] curve_x_q, curve_y_q;
  logic                   run_end_q;

  logic [3:0][COORD_WIDTH-1:0]   win_x, win_y;
  logic signed [COORD_WIDTH-1:0] res_x, res_y;
  logic                          out_free;
  logic                          in_fire;
  cst_op_t                       op;
  cst_ctl_t                      ctl;

  assign in_ready_o = ctl.in_ready;
  assign in_fire    = in_valid_i && ctl.in_ready;
  assign out_free   = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tension_q <= TENSION_RESET;
      grain_q   <= GRAIN_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_TENSION: tension_q <= cfg_data_i[TENSION_W-1:0];
        REG_GRAIN:   grain_q   <= cfg_data_i[GRAIN_W-1:0];
        default:     ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      cur_x_q <= point_x_i;
      cur_y_q <= point_y_i;
      last_q  <= is_last_i;
    end
  end

  // last point of a curve clears the history
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hist_x_q <= '0;
      hist_y_q <= '0;
      seen_q   <= '0;
    end else if (ctl.hist_upd) begin
      if (last_q) begin
        hist_x_q <= '0;
        hist_y_q <= '0;
        seen_q   <= '0;
      end else begin
        hist_x_q <= {hist_x_q[1:0], cur_x_q};
        hist_y_q <= {hist_y_q[1:0], cur_y_q};
        if (seen_q != 2'd3) seen_q <= seen_q + 2'd1;
      end
    end
  end

  // span window a, b, c, d; closing span doubles the last point
  always_comb begin
    if (ctl.span_b) begin
      win_x[0] = seen_q[1] ? hist_x_q[1] : hist_x_q[0];
      win_y[0] = seen_q[1] ? hist_y_q[1] : hist_y_q[0];
      win_x[1] = hist_x_q[0];
      win_y[1] = hist_y_q[0];
      win_x[2] = cur_x_q;
      win_y[2] = cur_y_q;
    end else begin
      win_x[0] = (seen_q == 2'd2) ? hist_x_q[1] : hist_x_q[2];
      win_y[0] = (seen_q == 2'd2) ? hist_y_q[1] : hist_y_q[2];
      win_x[1] = hist_x_q[1];
      win_y[1] = hist_y_q[1];
      win_x[2] = hist_x_q[0];
      win_y[2] = hist_y_q[0];
    end
    win_x[3] = cur_x_q;
    win_y[3] = cur_y_q;
  end

  cst_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .last_i     (last_q),
    .seen_i     (seen_q),
    .out_free_i (out_free),
    .grain_i    (grain_q),
    .op_o       (op),
    .ctl_o      (ctl)
  );

  cst_mac #(
    .COORD_WIDTH (COORD_WIDTH)
  ) u_mac (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .op_i      (op),
    .tension_i (tension_q),
    .win_x_i   (win_x),
    .win_y_i   (win_y),
    .res_x_o   (res_x),
    .res_y_o   (res_y)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (ctl.out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl.out_load) begin
      curve_x_q <= ctl.out_final ? cur_x_q : res_x;
      curve_y_q <= ctl.out_final ? cur_y_q : res_y;
      run_end_q <= ctl.out_end;
    end
  end

  assign out_valid_o = out_valid_q;
  assign curve_x_o   = curve_x_q;
  assign curve_y_o   = curve_y_q;
  assign run_end_o   = run_end_q;

endmodule

>>> rtl/core/cst_mac.sv
// Shared multiply-add unit: window differences, spline coefficients, Horner accumulators.
module cst_mac #(
  parameter int COORD_WIDTH = cst_pkg::DEF_COORD_WIDTH
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  cst_pkg::cst_op_t                       op_i,
  input  logic [cst_pkg::TENSION_W-1:0]          tension_i,
  input  logic [3:0][COORD_WIDTH-1:0]            win_x_i,
  input  logic [3:0][COORD_WIDTH-1:0]            win_y_i,
  output logic signed [COORD_WIDTH-1:0]          res_x_o,
  output logic signed [COORD_WIDTH-1:0]          res_y_o
);
  import cst_pkg::*;

  localparam int ACC_W  = COORD_WIDTH + 22;
  localparam int DIF_W  = COORD_WIDTH + 3;
  localparam int OPB_W  = U_W + 1;
  localparam int PROD_W = ACC_W + OPB_W;
  localparam int RES_W  = ACC_W - 14;
  localparam int HI_W   = RES_W - COORD_WIDTH + 1;

  logic [1:0][3:0][COORD_WIDTH-1:0] win;
  assign win[0] = win_x_i;
  assign win[1] = win_y_i;

  logic signed [DIF_W-1:0] wa [2];
  logic signed [DIF_W-1:0] wb [2];
  logic signed [DIF_W-1:0] wc [2];
  logic signed [DIF_W-1:0] wd [2];

  logic signed [DIF_W-1:0]       dif_q  [2][3];
  logic signed [DIF_W-1:0]       bc_q   [2];
  logic signed [COORD_WIDTH-1:0] b_q    [2];
  logic signed [ACC_W-1:0]       coef_q [2][3];
  logic signed [ACC_W-1:0]       acc_q  [2];
  logic signed [PROD_W-1:0]      prod_q, prod_d;
  logic signed [ACC_W-1:0]       add_q, add_d;
  logic                          wb_vld_q;
  logic                          wb_setup_q;
  logic                          wb_axis_q;
  logic [1:0]                    wb_k_q;

  logic signed [ACC_W-1:0] opa;
  logic signed [OPB_W-1:0] opb;
  logic signed [ACC_W-1:0] bc_ext;
  logic signed [ACC_W-1:0] sum;

  always_comb begin
    for (int ax = 0; ax < 2; ax++) begin
      wa[ax] = DIF_W'($signed(win[ax][0]));
      wb[ax] = DIF_W'($signed(win[ax][1]));
      wc[ax] = DIF_W'($signed(win[ax][2]));
      wd[ax] = DIF_W'($signed(win[ax][3]));
    end
  end

  // p0 = t*(d-a-b+c) + 32768*(b-c), p1 = t*(2a+b-2c-d) - 49152*(b-c), p2 = t*(c-a)
  always_ff @(posedge clk_i) begin
    if (op_i.load) begin
      for (int ax = 0; ax < 2; ax++) begin
        dif_q[ax][0] <= wd[ax] - wa[ax] - wb[ax] + wc[ax];
        dif_q[ax][1] <= (wa[ax] <<< 1) + wb[ax] - (wc[ax] <<< 1) - wd[ax];
        dif_q[ax][2] <= wc[ax] - wa[ax];
        bc_q[ax]     <= wb[ax] - wc[ax];
        b_q[ax]      <= $signed(win[ax][1]);
      end
    end
  end

  // issue stage
  always_comb begin
    bc_ext = ACC_W'(bc_q[op_i.axis]);
    if (op_i.setup) begin
      opb = $signed({2'b00, tension_i});
      case (op_i.k)
        2'd0: begin
          opa   = ACC_W'(dif_q[op_i.axis][0]);
          add_d = bc_ext <<< 15;
        end
        2'd1: begin
          opa   = ACC_W'(dif_q[op_i.axis][1]);
          add_d = -((bc_ext <<< 15) + (bc_ext <<< 14));
        end
        default: begin
          opa   = ACC_W'(dif_q[op_i.axis][2]);
          add_d = '0;
        end
      endcase
    end else begin
      opb = $signed({1'b0, op_i.u});
      opa = (op_i.k == 2'd1) ? coef_q[op_i.axis][0] : acc_q[op_i.axis];
      case (op_i.k)
        2'd1:    add_d = coef_q[op_i.axis][1];
        2'd2:    add_d = coef_q[op_i.axis][2];
        default: add_d = ACC_W'(b_q[op_i.axis]) <<< 14;
      endcase
    end
    prod_d = opa * opb;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wb_vld_q <= 1'b0;
    end else begin
      wb_vld_q <= op_i.issue;
    end
  end

  always_ff @(posedge clk_i) begin
    if (op_i.issue) begin
      prod_q     <= prod_d;
      add_q      <= add_d;
      wb_setup_q <= op_i.setup;
      wb_axis_q  <= op_i.axis;
      wb_k_q     <= op_i.k;
    end
  end

  // write-back stage; Horner product is floor(acc*u / 2^16)
  assign sum = (wb_setup_q ? $signed(prod_q[ACC_W-1:0]) : $signed(prod_q[ACC_W+15:16]))
               + add_q;

  always_ff @(posedge clk_i) begin
    if (wb_vld_q) begin
      if (wb_setup_q) begin
        case (wb_k_q)
          2'd0:    coef_q[wb_axis_q][0] <= sum;
          2'd1:    coef_q[wb_axis_q][1] <= sum;
          default: coef_q[wb_axis_q][2] <= sum;
        endcase
      end else begin
        acc_q[wb_axis_q] <= sum;
      end
    end
  end

  // round half up from Q22 to Q8, then saturate
  logic signed [ACC_W-1:0]       rnd [2];
  logic [RES_W-1:0]              shr [2];
  logic [HI_W-1:0]               hi  [2];
  logic signed [COORD_WIDTH-1:0] res [2];

  always_comb begin
    for (int ax = 0; ax < 2; ax++) begin
      rnd[ax] = acc_q[ax] + ACC_W'(8192);
      shr[ax] = rnd[ax][ACC_W-1:14];
      hi[ax]  = shr[ax][RES_W-1:COORD_WIDTH-1];
      if ((&hi[ax]) || !(|hi[ax])) begin
        res[ax] = shr[ax][COORD_WIDTH-1:0];
      end else if (hi[ax][HI_W-1]) begin
        res[ax] = {1'b1, {(COORD_WIDTH-1){1'b0}}};
      end else begin
        res[ax] = {1'b0, {(COORD_WIDTH-1){1'b1}}};
      end
    end
  end

  assign res_x_o = res[0];
  assign res_y_o = res[1];

endmodule

>>> rtl/core/cst_ctrl.sv
// Sequencer: span selection, coefficient and Horner op issue, u stepping, result hand-off.
module cst_ctrl (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  input  logic                         last_i,
  input  logic [1:0]                   seen_i,
  input  logic                         out_free_i,
  input  logic [cst_pkg::GRAIN_W-1:0]  grain_i,
  output cst_pkg::cst_op_t             op_o,
  output cst_pkg::cst_ctl_t            ctl_o
);
  import cst_pkg::*;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_SEL   = 4'd1;
  localparam logic [3:0] S_LOAD  = 4'd2;
  localparam logic [3:0] S_SETUP = 4'd3;
  localparam logic [3:0] S_HORN  = 4'd4;
  localparam logic [3:0] S_DRAIN = 4'd5;
  localparam logic [3:0] S_RES   = 4'd6;
  localparam logic [3:0] S_FINAL = 4'd7;
  localparam logic [3:0] S_DONE  = 4'd8;

  localparam logic [GRAIN_W-1:0] GMAX    = GRAIN_W'(MAX_GRAIN);
  localparam logic [2:0]         LAST_OP = 3'd5;

  logic [3:0]         state_q, state_d;
  logic [1:0]         phase_q, phase_d;
  logic               span_b_q, span_b_d;
  logic [2:0]         cnt_q, cnt_d;
  logic [GRAIN_W-1:0] j_q, j_d;
  logic [U_W-1:0]     u_q, u_d;
  logic [GRAIN_W-1:0] rem_q, rem_d;

  logic [GRAIN_W-1:0] g_eff, g_last;
  cst_step_t          step;
  logic [GRAIN_W:0]   rsum;
  logic               wrap;
  logic [GRAIN_W-1:0] rem_next;
  logic [U_W-1:0]     u_next;

  always_comb begin
    if (grain_i == '0) begin
      g_eff = GRAIN_W'(1);
    end else if (grain_i > GMAX) begin
      g_eff = GMAX;
    end else begin
      g_eff = grain_i;
    end
  end

  assign g_last = g_eff - GRAIN_W'(1);
  assign step   = u_step(g_eff);

  // u = floor(j*65536/g) stepped as q per point plus a carry from the remainder
  assign rsum     = {1'b0, rem_q} + {1'b0, step.r};
  assign wrap     = rsum >= {1'b0, g_eff};
  assign rem_next = wrap ? GRAIN_W'(rsum - {1'b0, g_eff}) : rsum[GRAIN_W-1:0];
  assign u_next   = u_q + step.q + U_W'(wrap);

  always_comb begin
    state_d  = state_q;
    phase_d  = phase_q;
    span_b_d = span_b_q;
    cnt_d    = cnt_q;
    j_d      = j_q;
    u_d      = u_q;
    rem_d    = rem_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          state_d = S_SEL;
          phase_d = 2'd0;
        end
      end
      S_SEL: begin
        case (phase_q)
          2'd0: begin
            phase_d = 2'd1;
            if (seen_i[1]) begin
              span_b_d = 1'b0;
              state_d  = S_LOAD;
            end
          end
          2'd1: begin
            phase_d = 2'd2;
            if (last_i && (seen_i != 2'd0)) begin
              span_b_d = 1'b1;
              state_d  = S_LOAD;
            end
          end
          default: state_d = last_i ? S_FINAL : S_DONE;
        endcase
      end
      S_LOAD: begin
        state_d = S_SETUP;
        cnt_d   = '0;
        j_d     = '0;
        u_d     = '0;
        rem_d   = '0;
      end
      S_SETUP: begin
        if (cnt_q == LAST_OP) begin
          cnt_d   = '0;
          state_d = S_HORN;
        end else begin
          cnt_d = cnt_q + 3'd1;
        end
      end
      S_HORN: begin
        if (cnt_q == LAST_OP) begin
          state_d = S_DRAIN;
        end else begin
          cnt_d = cnt_q + 3'd1;
        end
      end
      S_DRAIN: state_d = S_RES;
      S_RES: begin
        if (out_free_i) begin
          if (j_q == g_last) begin
            state_d = S_SEL;
          end else begin
            j_d     = j_q + GRAIN_W'(1);
            u_d     = u_next;
            rem_d   = rem_next;
            cnt_d   = '0;
            state_d = S_HORN;
          end
        end
      end
      S_FINAL: begin
        if (out_free_i) state_d = S_DONE;
      end
      S_DONE: state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      phase_q  <= '0;
      span_b_q <= 1'b0;
      cnt_q    <= '0;
      j_q      <= '0;
      u_q      <= '0;
      rem_q    <= '0;
    end else begin
      state_q  <= state_d;
      phase_q  <= phase_d;
      span_b_q <= span_b_d;
      cnt_q    <= cnt_d;
      j_q      <= j_d;
      u_q      <= u_d;
      rem_q    <= rem_d;
    end
  end

  // ops alternate x / y so each write-back lands before the same axis reads again
  always_comb begin
    op_o.load  = (state_q == S_LOAD);
    op_o.issue = (state_q == S_SETUP) || (state_q == S_HORN);
    op_o.setup = (state_q == S_SETUP);
    op_o.axis  = cnt_q[0];
    op_o.k     = (state_q == S_SETUP) ? cnt_q[2:1] : cnt_q[2:1] + 2'd1;
    op_o.u     = u_q;
  end

  always_comb begin
    ctl_o.in_ready  = (state_q == S_IDLE);
    ctl_o.hist_upd  = (state_q == S_DONE);
    ctl_o.out_load  = ((state_q == S_RES) || (state_q == S_FINAL)) && out_free_i;
    ctl_o.out_final = (state_q == S_FINAL);
    ctl_o.out_end   = (state_q == S_FINAL) || ((j_q == g_last) && !last_i);
    ctl_o.span_b    = span_b_q;
  end

endmodule
